// ----- hdl/periodic_task_scheduler_rm_edf_core_assert.svh -----
// Assertion macros shared by the scheduler checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef PERIODIC_TASK_SCHEDULER_RM_EDF_CORE_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_RM_EDF_CORE_ASSERT_SVH

// Same-cycle implication, disabled while rst is low
`define PTSC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while rst is low
`define PTSC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ptsc_pkg.sv -----
// Package for the periodic task scheduler: command, record and state codes,
// entry table and record types, saturating counter helper. No dependencies.
package ptsc_pkg;

  localparam logic [15:0] SAT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REC_IDLE    = 3'd0,
    REC_PREEMPT = 3'd1,
    REC_FINISH  = 3'd2,
    REC_LOST    = 3'd3,
    REC_REPORT  = 3'd4,
    REC_REJECT  = 3'd5
  } rec_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REL,
    ST_DEC,
    ST_EMIT,
    ST_MISS,
    ST_RFLUSH,
    ST_RSCAN,
    ST_REMIT
  } state_t;

  // one output record
  typedef struct packed {
    rec_kind_t   kind;
    logic [2:0]  task_id;
    logic [15:0] units;
    logic [15:0] lost;
    logic [15:0] done;
    logic        killed;
    logic        last;
  } rec_t;

  // fixed-width part of a task entry
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] deadline;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [15:0] lost;
    logic [15:0] done;
    logic        active;
  } ent_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == SAT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// ----- hdl/periodic_task_scheduler_rm_edf_core.sv -----
// Periodic real-time task scheduler (rate monotonic or EDF) over a table of
// MAX_TASKS entries kept in two synchronous memories, each with one read
// port, one write port and a registered read. A transaction is taken only
// while the block is idle. A load is validated and written, or rejected
// once the output slot is free. A tick makes two passes over the entry table
// (release and pick, then deadline check), one read per entry per cycle, set
// by the single read port, and between them runs one unit and emits its
// records. A report flushes any pending idle record, then scans the table,
// skipping empty entries and emitting one record per loaded entry.
// No clearing pass after reset: per-entry valid bits gate every read.
// Depends on ptsc_pkg and ptsc_out_reg.
module periodic_task_scheduler_rm_edf_core #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_task_index,
  input  logic [15:0] in_period_ticks,
  input  logic [15:0] in_deadline_ticks,
  input  logic [15:0] in_burst_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_record_kind,
  output logic [2:0]  out_record_task,
  output logic [15:0] out_segment_units,
  output logic [15:0] out_lost_count,
  output logic [15:0] out_complete_count,
  output logic        out_killed_count,
  output logic        out_last_record
);
  import ptsc_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CTR_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
  localparam logic [CTR_W-1:0] N_ENT = CTR_W'(MAX_TASKS);

  // control state
  state_t                 state_r, state_nxt;
  logic                   policy_r;
  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic                   run_vld_r, run_vld_nxt;
  logic [IDX_W-1:0]       run_task_r, run_task_nxt;
  logic [15:0]            run_units_r, run_units_nxt;
  logic [15:0]            idle_r, idle_nxt;
  logic [MAX_TASKS-1:0]   ent_vld_r, ent_vld_nxt;
  logic [CTR_W-1:0]       cnt_r, cnt_nxt;
  logic                   proc_vld_r, proc_vld_nxt;
  logic                   best_vld_r, best_vld_nxt;
  logic [3:0]             pend_r, pend_nxt;
  logic [CTR_W-1:0]       scan_r, scan_nxt;

  // payload registers
  logic [2:0]             cmd_idx_r;
  logic [15:0]            per_r, dl_r, bu_r;
  logic [IDX_W-1:0]       proc_idx_r, proc_idx_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  ent_t                   best_ent_r, best_ent_nxt;
  logic [TIME_BITS-1:0]   best_nr_r, best_nr_nxt, best_ad_r, best_ad_nxt;
  logic [15:0]            idle_val_r, idle_val_nxt;
  logic [IDX_W-1:0]       h_task_r, h_task_nxt;
  logic [15:0]            h_units_r, h_units_nxt;
  logic [IDX_W-1:0]       fl_task_r, fl_task_nxt;
  logic [15:0]            fl_units_r, fl_units_nxt;

  // entry table: fixed fields and time fields {next_release, abs_deadline}
  ent_t                   ent_mem [MAX_TASKS];
  logic [2*TIME_BITS-1:0] tm_mem  [MAX_TASKS];
  ent_t                   ent_rd_r;
  logic [2*TIME_BITS-1:0] tm_rd_r;
  logic                   rd_en, we;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  ent_t                   wr_ent;
  logic [2*TIME_BITS-1:0] wr_tm;

  // record path
  logic                   rec_ld, rec_free;
  rec_t                   rec_d;
  logic                   in_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // table memories
  always_ff @(posedge clk) begin
    if (we) begin
      ent_mem[wr_addr] <= wr_ent;
      tm_mem[wr_addr]  <= wr_tm;
    end
    if (rd_en) begin
      ent_rd_r <= ent_mem[rd_addr];
      tm_rd_r  <= tm_mem[rd_addr];
    end
  end

  // captured command
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_idx_r <= in_task_index;
      per_r     <= in_period_ticks;
      dl_r      <= in_deadline_ticks;
      bu_r      <= in_burst_ticks;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
    end else if (cfg_wr_en) begin
      policy_r <= cfg_wr_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      run_vld_r   <= 1'b0;
      run_task_r  <= '0;
      run_units_r <= '0;
      idle_r      <= '0;
      ent_vld_r   <= '0;
      cnt_r       <= '0;
      proc_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
      pend_r      <= '0;
      scan_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      run_vld_r   <= run_vld_nxt;
      run_task_r  <= run_task_nxt;
      run_units_r <= run_units_nxt;
      idle_r      <= idle_nxt;
      ent_vld_r   <= ent_vld_nxt;
      cnt_r       <= cnt_nxt;
      proc_vld_r  <= proc_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      pend_r      <= pend_nxt;
      scan_r      <= scan_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_ent_r <= best_ent_nxt;
    best_nr_r  <= best_nr_nxt;
    best_ad_r  <= best_ad_nxt;
    idle_val_r <= idle_val_nxt;
    h_task_r   <= h_task_nxt;
    h_units_r  <= h_units_nxt;
    fl_task_r  <= fl_task_nxt;
    fl_units_r <= fl_units_nxt;
  end

  // sequencer: next state, table accesses, records
  always_comb begin
    ent_t                 e;
    logic [TIME_BITS-1:0] nr, ad, tnext;
    logic                 rel, cand, better, miss, ok, more;
    logic [15:0]          ru, idle_n;
    logic                 rv;
    logic [IDX_W-1:0]     rt, sidx;
    logic [3:0]           pn;

    state_nxt     = state_r;
    time_nxt      = time_r;
    run_vld_nxt   = run_vld_r;
    run_task_nxt  = run_task_r;
    run_units_nxt = run_units_r;
    idle_nxt      = idle_r;
    ent_vld_nxt   = ent_vld_r;
    cnt_nxt       = cnt_r;
    proc_vld_nxt  = proc_vld_r;
    best_vld_nxt  = best_vld_r;
    pend_nxt      = pend_r;
    scan_nxt      = scan_r;
    proc_idx_nxt  = proc_idx_r;
    best_idx_nxt  = best_idx_r;
    best_ent_nxt  = best_ent_r;
    best_nr_nxt   = best_nr_r;
    best_ad_nxt   = best_ad_r;
    idle_val_nxt  = idle_val_r;
    h_task_nxt    = h_task_r;
    h_units_nxt   = h_units_r;
    fl_task_nxt   = fl_task_r;
    fl_units_nxt  = fl_units_r;

    rd_en   = 1'b0;
    rd_addr = cnt_r[IDX_W-1:0];
    we      = 1'b0;
    wr_addr = proc_idx_r;
    wr_ent  = ent_rd_r;
    wr_tm   = tm_rd_r;
    rec_ld  = 1'b0;
    rec_d   = '0;

    e      = ent_rd_r;
    {nr, ad} = tm_rd_r;
    tnext  = time_r + TIME_BITS'(1);
    rel    = 1'b0;
    cand   = 1'b0;
    better = 1'b0;
    miss   = 1'b0;
    ok     = 1'b0;
    more   = 1'b0;
    ru     = run_units_r;
    idle_n = idle_r;
    rv     = run_vld_r;
    rt     = run_task_r;
    pn     = '0;
    sidx   = scan_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_command))
            CMD_LOAD:   state_nxt = ST_LOAD;
            CMD_TICK: begin
              cnt_nxt      = '0;
              proc_vld_nxt = 1'b0;
              best_vld_nxt = 1'b0;
              state_nxt    = ST_REL;
            end
            CMD_REPORT: state_nxt = ST_RFLUSH;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end

      // validate and write one entry, or reject it
      ST_LOAD: begin
        ok = (32'(cmd_idx_r) < MAX_TASKS) && (per_r != 16'd0) && (dl_r != 16'd0) &&
             (bu_r != 16'd0) && (bu_r <= dl_r) && (dl_r <= per_r);
        if (ok) begin
          we                   = 1'b1;
          wr_addr              = IDX_W'(cmd_idx_r);
          wr_ent.period        = per_r;
          wr_ent.deadline      = dl_r;
          wr_ent.burst         = bu_r;
          wr_ent.remaining     = bu_r;
          wr_ent.lost          = '0;
          wr_ent.done          = '0;
          wr_ent.active        = 1'b1;
          wr_tm                = {TIME_BITS'(0), TIME_BITS'(dl_r)};
          ent_vld_nxt[wr_addr] = 1'b1;
          state_nxt            = ST_IDLE;
        end else if (rec_free) begin
          rec_ld        = 1'b1;
          rec_d.kind    = REC_REJECT;
          rec_d.task_id = cmd_idx_r;
          rec_d.last    = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // pass one: release due jobs and pick the winner
      ST_REL: begin
        if (cnt_r < N_ENT) begin
          rd_en   = 1'b1;
          cnt_nxt = cnt_r + CTR_W'(1);
        end
        proc_vld_nxt = (cnt_r < N_ENT);
        proc_idx_nxt = cnt_r[IDX_W-1:0];
        if (proc_vld_r) begin
          rel = ent_vld_r[proc_idx_r] && (nr == time_r);
          if (rel) begin
            e.remaining = e.burst;
            ad          = nr + TIME_BITS'(e.deadline);
            e.active    = 1'b1;
          end
          we     = rel;
          wr_ent = e;
          wr_tm  = {nr, ad};
          cand   = ent_vld_r[proc_idx_r] && e.active;
          better = policy_r ? (ad < best_ad_r) : (e.period < best_ent_r.period);
          if (cand && (!best_vld_r || better)) begin
            best_vld_nxt = 1'b1;
            best_idx_nxt = proc_idx_r;
            best_ent_nxt = e;
            best_nr_nxt  = nr;
            best_ad_nxt  = ad;
          end
          if (proc_idx_r == LAST_IDX) begin
            state_nxt = ST_DEC;
          end
        end
      end

      // switch, run one unit, detect finish or loss of the running job
      ST_DEC: begin
        e      = best_ent_r;
        nr     = best_nr_r;
        ad     = best_ad_r;
        idle_n = best_vld_r ? idle_r : sat_inc(idle_r);
        if ((best_vld_r != run_vld_r) || (best_vld_r && (best_idx_r != run_task_r))) begin
          if (idle_n != 16'd0) begin
            pn[0]        = 1'b1;
            idle_val_nxt = idle_n;
            idle_n       = '0;
          end
          if (run_vld_r) begin
            pn[1]       = 1'b1;
            h_task_nxt  = run_task_r;
            h_units_nxt = run_units_r;
          end
          rv = best_vld_r;
          rt = best_vld_r ? best_idx_r : '0;
          ru = '0;
        end
        if (best_vld_r) begin
          ru = sat_inc(ru);
          if (e.remaining != 16'd0) begin
            e.remaining = e.remaining - 16'd1;
          end
          fl_task_nxt  = best_idx_r;
          fl_units_nxt = ru;
          if (e.remaining == 16'd0) begin
            pn[2]    = 1'b1;
            e.done   = sat_inc(e.done);
            e.active = 1'b0;
            nr       = nr + TIME_BITS'(e.period);
            rv       = 1'b0;
            rt       = '0;
            ru       = '0;
          end else if (tnext == ad) begin
            pn[3] = 1'b1;
            rv    = 1'b0;
            rt    = '0;
            ru    = '0;
          end
          we      = 1'b1;
          wr_addr = best_idx_r;
          wr_ent  = e;
          wr_tm   = {nr, ad};
        end
        idle_nxt      = idle_n;
        run_vld_nxt   = rv;
        run_task_nxt  = rt;
        run_units_nxt = ru;
        pend_nxt      = pn;
        cnt_nxt       = '0;
        proc_vld_nxt  = 1'b0;
        state_nxt     = ST_EMIT;
      end

      // records in order: idle, preempted, finished or lost
      ST_EMIT: begin
        if (pend_r == 4'd0) begin
          state_nxt = ST_MISS;
        end else if (rec_free) begin
          rec_ld = 1'b1;
          if (pend_r[0]) begin
            rec_d.kind  = REC_IDLE;
            rec_d.units = idle_val_r;
            pn          = pend_r & 4'b1110;
          end else if (pend_r[1]) begin
            rec_d.kind    = REC_PREEMPT;
            rec_d.task_id = 3'(h_task_r);
            rec_d.units   = h_units_r;
            pn            = pend_r & 4'b1100;
          end else begin
            rec_d.kind    = pend_r[2] ? REC_FINISH : REC_LOST;
            rec_d.task_id = 3'(fl_task_r);
            rec_d.units   = fl_units_r;
            pn            = '0;
          end
          rec_d.last = (pn == 4'd0);
          pend_nxt   = pn;
        end
      end

      // pass two: deadline misses, then advance time
      ST_MISS: begin
        if (cnt_r < N_ENT) begin
          rd_en   = 1'b1;
          cnt_nxt = cnt_r + CTR_W'(1);
        end
        proc_vld_nxt = (cnt_r < N_ENT);
        proc_idx_nxt = cnt_r[IDX_W-1:0];
        if (proc_vld_r) begin
          miss = ent_vld_r[proc_idx_r] && e.active && (e.remaining != 16'd0) && (tnext == ad);
          if (miss) begin
            e.lost      = sat_inc(e.lost);
            e.active    = 1'b0;
            e.remaining = '0;
            nr          = nr + TIME_BITS'(e.period);
          end
          we     = miss;
          wr_ent = e;
          wr_tm  = {nr, ad};
          if (proc_idx_r == LAST_IDX) begin
            time_nxt  = tnext;
            state_nxt = ST_IDLE;
          end
        end
      end

      // report: pending idle first
      ST_RFLUSH: begin
        if (idle_r == 16'd0) begin
          scan_nxt  = '0;
          state_nxt = ST_RSCAN;
        end else if (rec_free) begin
          rec_ld      = 1'b1;
          rec_d.kind  = REC_IDLE;
          rec_d.units = idle_r;
          rec_d.last  = (ent_vld_r == '0);
          idle_nxt    = '0;
          scan_nxt    = '0;
          state_nxt   = ST_RSCAN;
        end
      end

      ST_RSCAN: begin
        if (scan_r == N_ENT) begin
          state_nxt = ST_IDLE;
        end else if (!ent_vld_r[sidx]) begin
          scan_nxt = scan_r + CTR_W'(1);
        end else begin
          rd_en     = 1'b1;
          rd_addr   = sidx;
          state_nxt = ST_REMIT;
        end
      end

      ST_REMIT: begin
        for (int k = 0; k < MAX_TASKS; k++) begin
          if ((CTR_W'(k) > scan_r) && ent_vld_r[k]) begin
            more = 1'b1;
          end
        end
        if (rec_free) begin
          rec_ld        = 1'b1;
          rec_d.kind    = REC_REPORT;
          rec_d.task_id = 3'(sidx);
          rec_d.lost    = ent_rd_r.lost;
          rec_d.done    = ent_rd_r.done;
          rec_d.killed  = ent_rd_r.active && (ent_rd_r.remaining != 16'd0);
          rec_d.last    = !more;
          scan_nxt      = scan_r + CTR_W'(1);
          state_nxt     = ST_RSCAN;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  ptsc_out_reg u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec_ld             (rec_ld),
    .rec_d              (rec_d),
    .rec_free           (rec_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_kind    (out_record_kind),
    .out_record_task    (out_record_task),
    .out_segment_units  (out_segment_units),
    .out_lost_count     (out_lost_count),
    .out_complete_count (out_complete_count),
    .out_killed_count   (out_killed_count),
    .out_last_record    (out_last_record)
  );

endmodule

// ----- hdl/ptsc_out_reg.sv -----
// Output holding register for scheduler records.
// Depends on ptsc_pkg (rec_t).
module ptsc_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rec_ld,
  input  ptsc_pkg::rec_t  rec_d,
  output logic            rec_free,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      out_record_kind,
  output logic [2:0]      out_record_task,
  output logic [15:0]     out_segment_units,
  output logic [15:0]     out_lost_count,
  output logic [15:0]     out_complete_count,
  output logic            out_killed_count,
  output logic            out_last_record
);
  import ptsc_pkg::*;

  logic valid_r;
  rec_t rec_r;

  // slot is free when empty or the held transaction leaves this cycle
  assign rec_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rec_ld) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ld) begin
      rec_r <= rec_d;
    end
  end

  assign out_valid          = valid_r;
  assign out_record_kind    = rec_r.kind;
  assign out_record_task    = rec_r.task_id;
  assign out_segment_units  = rec_r.units;
  assign out_lost_count     = rec_r.lost;
  assign out_complete_count = rec_r.done;
  assign out_killed_count   = rec_r.killed;
  assign out_last_record    = rec_r.last;

endmodule

// ----- hdl/ptsc_checker.sv -----
// Port-level checker for the scheduler core, bound to the top level.
// Depends on ptsc_pkg and periodic_task_scheduler_rm_edf_core_assert.svh.
`include "periodic_task_scheduler_rm_edf_core_assert.svh"

module ptsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_record_kind,
  input logic [2:0]  out_record_task,
  input logic [15:0] out_segment_units,
  input logic        out_killed_count
);
  import ptsc_pkg::*;

  // a stalled record holds
  `PTSC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_record_kind) && $stable(out_segment_units), "stalled record changed")

  // only defined record codes leave the block
  `PTSC_ASSERT_IMP(a_kind_defined, clk, rst_n, out_valid, out_record_kind <= REC_REJECT, "undefined record kind")

  // idle segments are never empty and name no task
  `PTSC_ASSERT_IMP(a_idle_shape, clk, rst_n, out_valid && (out_record_kind == REC_IDLE), (out_record_task == 3'd0) && (out_segment_units != 16'd0), "bad idle segment")

  // killed flag appears on report records only
  `PTSC_ASSERT_IMP(a_killed_report, clk, rst_n, out_valid && out_killed_count, out_record_kind == REC_REPORT, "killed flag outside report")

  // reset empties the output slot
  `PTSC_ASSERT_NXT(a_rst_clear, clk, 1'b1, !rst_n, !out_valid, "output valid after reset")

endmodule

bind periodic_task_scheduler_rm_edf_core ptsc_checker u_ptsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_record_kind   (out_record_kind),
  .out_record_task   (out_record_task),
  .out_segment_units (out_segment_units),
  .out_killed_count  (out_killed_count)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the periodic task scheduler core (RM / EDF).
// Depends on ptsc_pkg and periodic_task_scheduler_rm_edf_core; stand-alone.
module tb;
  import ptsc_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  task_id;
    logic [15:0] units;
    logic [15:0] lost;
    logic [15:0] done;
    logic        killed;
    logic        last;
  } sched_rec_t;

  // Scheduler predictor plus queue of expected records
  class sched_scoreboard;
    bit          policy_edf;
    bit          valid_q [8];
    bit [15:0]   period_q [8];
    bit [15:0]   dline_q [8];
    bit [15:0]   burst_q [8];
    bit [15:0]   remain_q [8];
    bit [31:0]   release_q [8];
    bit [31:0]   absdl_q [8];
    bit          active_q [8];
    bit [15:0]   lost_q [8];
    bit [15:0]   done_q [8];
    bit [31:0]   now;
    bit          run_valid;
    bit [2:0]    run_task;
    bit [15:0]   run_units;
    bit [15:0]   idle_units;
    sched_rec_t  pending_recs [$];
    sched_rec_t  batch [$];
    int          mismatches;
    int          checked;

    function new();
      now = 0; run_valid = 0; run_task = 0; run_units = 0; idle_units = 0;
      policy_edf = 0; mismatches = 0; checked = 0;
      foreach (valid_q[i]) begin
        valid_q[i] = 0; active_q[i] = 0; remain_q[i] = 0;
      end
    endfunction

    function bit [15:0] sat16(bit [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function void put(bit [2:0] k, bit [2:0] t, bit [15:0] u,
                      bit [15:0] l, bit [15:0] d, bit kl);
      sched_rec_t r;
      r = '{k, t, u, l, d, kl, 1'b0};
      batch.push_back(r);
    endfunction

    function void flush_idle();
      if (idle_units != 0) begin
        put(REC_IDLE, 3'd0, idle_units, 16'd0, 16'd0, 1'b0);
        idle_units = 0;
      end
    endfunction

    function void do_tick();
      bit       got;
      bit [2:0] pick;
      got = 0; pick = 0;
      for (int i = 0; i < 8; i++)
        if (valid_q[i] && release_q[i] == now) begin
          remain_q[i] = burst_q[i];
          absdl_q[i] = release_q[i] + 32'(dline_q[i]);
          active_q[i] = 1;
        end
      for (int i = 0; i < 8; i++) begin
        if (!valid_q[i] || !active_q[i]) continue;
        if (!got) begin
          got = 1; pick = 3'(i);
        end else if (!policy_edf) begin
          if (period_q[i] < period_q[pick]) pick = 3'(i);
        end else if (absdl_q[i] < absdl_q[pick]) pick = 3'(i);
      end
      if (!got) idle_units = sat16(idle_units);
      if (got != run_valid || (got && pick != run_task)) begin
        flush_idle();
        if (run_valid) put(REC_PREEMPT, run_task, run_units, 16'd0, 16'd0, 1'b0);
        run_valid = got;
        run_task = got ? pick : 3'd0;
        run_units = 0;
      end
      if (got) begin
        run_units = sat16(run_units);
        if (remain_q[pick] > 0) remain_q[pick]--;
        if (remain_q[pick] == 0) begin
          put(REC_FINISH, pick, run_units, 16'd0, 16'd0, 1'b0);
          done_q[pick] = sat16(done_q[pick]);
          active_q[pick] = 0;
          release_q[pick] = release_q[pick] + 32'(period_q[pick]);
          run_valid = 0; run_task = 0; run_units = 0;
        end
      end
      // deadline misses
      for (int i = 0; i < 8; i++)
        if (valid_q[i] && active_q[i] && remain_q[i] > 0 && now + 32'd1 == absdl_q[i]) begin
          if (run_valid && run_task == 3'(i)) begin
            put(REC_LOST, 3'(i), run_units, 16'd0, 16'd0, 1'b0);
            run_valid = 0; run_task = 0; run_units = 0;
          end
          lost_q[i] = sat16(lost_q[i]);
          active_q[i] = 0;
          remain_q[i] = 0;
          release_q[i] = release_q[i] + 32'(period_q[i]);
        end
      now = now + 32'd1;
    endfunction

    // Note one accepted input transaction
    function void note_input(bit [1:0] cmd, bit [2:0] idx, bit [15:0] p,
                             bit [15:0] d, bit [15:0] b);
      batch.delete();
      case (cmd)
        CMD_LOAD: begin
          if (p == 0 || d == 0 || b == 0 || b > d || d > p)
            put(REC_REJECT, idx, 16'd0, 16'd0, 16'd0, 1'b0);
          else begin
            valid_q[idx] = 1; period_q[idx] = p; dline_q[idx] = d;
            burst_q[idx] = b; remain_q[idx] = b; release_q[idx] = 0;
            absdl_q[idx] = {16'd0, d}; active_q[idx] = 1;
            lost_q[idx] = 0; done_q[idx] = 0;
          end
        end
        CMD_TICK: do_tick();
        CMD_REPORT: begin
          flush_idle();
          for (int i = 0; i < 8; i++)
            if (valid_q[i])
              put(REC_REPORT, 3'(i), 16'd0, lost_q[i], done_q[i],
                  active_q[i] && remain_q[i] > 0);
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_recs.push_back(batch[i]);
    endfunction

    // Check one accepted result transaction
    function void check_result(sched_rec_t got);
      sched_rec_t exp_r;
      checked++;
      if (pending_recs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %p", got);
        return;
      end
      exp_r = pending_recs.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("record mismatch: exp %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_wr_en, cfg_wr_data;
  logic        in_valid, in_stall;
  logic [1:0]  in_command;
  logic [2:0]  in_task_index;
  logic [15:0] in_period_ticks, in_deadline_ticks, in_burst_ticks;
  logic        out_valid, out_stall;
  logic [2:0]  out_record_kind, out_record_task;
  logic [15:0] out_segment_units, out_lost_count, out_complete_count;
  logic        out_killed_count, out_last_record;

  periodic_task_scheduler_rm_edf_core uut (.*);

  sched_scoreboard sb;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_off;
  int  cycles;
  int  items_sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_record_kind, out_record_task, out_segment_units,
                        out_lost_count, out_complete_count, out_killed_count,
                        out_last_record});
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb failed");
      $finish;
    end
  end

  // Offer one transaction and wait until it is taken; valid stays up after
  // acceptance so the next transaction can follow directly
  task automatic send_cmd(bit [1:0] cmd, bit [2:0] idx, bit [15:0] p,
                          bit [15:0] d, bit [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_command <= cmd; in_task_index <= idx;
    in_period_ticks <= p; in_deadline_ticks <= d; in_burst_ticks <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, idx, p, d, b);
    items_sent++;
  endtask

  // Drain expected records, then let the block settle before a config write
  task automatic drain_then_cfg(bit mode);
    in_valid <= 0;
    while (sb.pending_recs.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1; cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.policy_edf = mode;
  endtask

  task automatic load_task(bit [2:0] idx, bit [15:0] p, bit [15:0] d, bit [15:0] b);
    send_cmd(CMD_LOAD, idx, p, d, b);
  endtask

  // Random phase: mostly sane task sets and ticks, some noise
  task automatic random_items(int n);
    int r;
    bit [15:0] p, d, b;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        p = 16'($urandom_range(12, 2)); d = 16'($urandom_range(p, 1));
        b = 16'($urandom_range(d, 1));
        load_task(3'($urandom_range(7)), p, d, b);
      end else if (r < 20) begin
        send_cmd(CMD_LOAD, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 90)
        send_cmd(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 97)
        send_cmd(CMD_REPORT, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_cmd(CMD_NONE, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0; cfg_wr_en = 0; cfg_wr_data = 0; in_valid = 0;
    in_command = CMD_NONE; in_task_index = 0; in_period_ticks = 0;
    in_deadline_ticks = 0; in_burst_ticks = 0; out_stall = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; cycles = 0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty report, idle ticks, rejects, extremes, miss and preempt
    send_cmd(CMD_REPORT, 0, 0, 0, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_NONE, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_task(0, 0, 0, 0);
    load_task(1, 4, 5, 1);
    load_task(2, 4, 3, 4);
    load_task(3, 4, 4, 0);
    load_task(7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_task(0, 6, 3, 2);
    load_task(1, 4, 2, 2);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    load_task(7, 3, 1, 1);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    load_task(1, 5, 5, 5);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_REPORT, 0, 0, 0, 0);
    drain_then_cfg(1);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_REPORT, 0, 0, 0, 0);

    // Random phases with different idle mixes and both policies
    random_items(50);
    send_idle_pct = 59; random_items(40);
    drain_then_cfg(0);
    send_idle_pct = 0; recv_stall_pct = 59; random_items(40);
    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_items(20);
    join
    drain_then_cfg(1);
    send_idle_pct = 36; recv_stall_pct = 36; random_items(40);
    send_cmd(CMD_REPORT, 0, 0, 0, 0);
    in_valid <= 0;

    while (sb.pending_recs.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("ran %0d input transactions, checked %0d records, RM and EDF",
             items_sent, sb.checked);
    if (sb.mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
